/* sv/json_string_unescape_utf8_unit_assert.svh */
// Assertion macros for the JSON string unescape unit checker.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JSU_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define JSU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/jsu_pkg.sv */
// Types and constants shared by the JSON string unescape unit.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int IDX_W       = 2;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [3:0] E_NO_QUOTE  = 4'd0;
  localparam logic [3:0] E_CONTROL   = 4'd1;
  localparam logic [3:0] E_END_ESC   = 4'd2;
  localparam logic [3:0] E_BAD_ESC   = 4'd3;
  localparam logic [3:0] E_BAD_HEX   = 4'd4;
  localparam logic [3:0] E_NO_LOW    = 4'd5;
  localparam logic [3:0] E_BAD_LOW   = 4'd6;
  localparam logic [3:0] E_BAD_CP    = 4'd7;
  localparam logic [3:0] E_UNTERM    = 4'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [1:0] status;
    logic [3:0] error_code;
    logic       error_class;
    logic       last;
  } out_t;

  // One queued action: a single direct result or a code point to expand.
  typedef struct packed {
    logic        is_cp;
    logic        has_data;
    logic [1:0]  status;
    logic [3:0]  code;
    logic [20:0] val;
  } cmd_t;

endpackage

/* sv/json_string_unescape_utf8_unit.sv */
// Top level: JSON string literal unescaper with UTF-8 output.
// Accepts one input beat per cycle while the action queue has room.
// An accepted input beat's action is written into the queue, then loaded into the output register.
// Each beat makes one result, a \u escape up to four; the output register
// sends one result beat per cycle while out_ready is high, the queue absorbs multi-byte bursts.
// Synchronous active-low reset clears parser state, queue and output valid.
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit #(
  parameter int QDEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  logic          push, q_full, pop, head_valid;
  jsu_pkg::cmd_t push_cmd, head_cmd;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  jsu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* sv/jsu_front.sv */
// Front end: parses input bytes and queues result actions.
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_data,
  output logic          push,
  output jsu_pkg::cmd_t push_cmd,
  input  logic          q_full
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_STR     = 3'd1;
  localparam logic [2:0] PH_ESC     = 3'd2;
  localparam logic [2:0] PH_HEX     = 3'd3;
  localparam logic [2:0] PH_LOW_BSL = 3'd4;
  localparam logic [2:0] PH_LOW_U   = 3'd5;
  localparam logic [2:0] PH_LOW_HEX = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic [7:0]  c;
  logic        eoi;
  logic        hv;
  logic [3:0]  hd;
  logic [15:0] hex_sh;
  logic        do_fail;
  logic [3:0]  fcode;
  jsu_pkg::cmd_t ent;

  function automatic logic [4:0] hex_dec(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  assign c        = in_data.in_byte;
  assign eoi      = in_data.end_of_input;
  assign {hv, hd} = hex_dec(c);
  assign hex_sh   = {hex_r[11:0], hd};
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    do_fail   = 1'b0;
    fcode     = jsu_pkg::E_NO_QUOTE;
    ent       = '0;
    unique case (phase_r)
      PH_STR: begin
        if (eoi) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_UNTERM;
        end else if (c == 8'h22) begin
          phase_nxt  = PH_IDLE;
          ent.status = jsu_pkg::ST_DONE;
        end else if (c < 8'h20) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_CONTROL;
        end else if (c == 8'h5C) begin
          phase_nxt = PH_ESC;
        end else begin
          ent.has_data = 1'b1;
          ent.val      = {13'd0, c};
        end
      end
      PH_ESC: begin
        if (eoi) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_END_ESC;
        end else begin
          phase_nxt    = PH_STR;
          ent.has_data = 1'b1;
          case (c)
            8'h22: ent.val = 21'h22;
            8'h5C: ent.val = 21'h5C;
            8'h2F: ent.val = 21'h2F;
            8'h62: ent.val = 21'h08;
            8'h66: ent.val = 21'h0C;
            8'h6E: ent.val = 21'h0A;
            8'h72: ent.val = 21'h0D;
            8'h74: ent.val = 21'h09;
            8'h75: begin
              ent.has_data = 1'b0;
              phase_nxt    = PH_HEX;
              hex_nxt      = '0;
              cnt_nxt      = '0;
            end
            default: begin
              ent.has_data = 1'b0;
              do_fail = 1'b1; fcode = jsu_pkg::E_BAD_ESC;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (eoi || !hv) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_BAD_HEX;
        end else begin
          hex_nxt = hex_sh;
          if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            if (hex_sh >= 16'hD800 && hex_sh <= 16'hDBFF) begin
              hi_nxt    = hex_sh[9:0];
              phase_nxt = PH_LOW_BSL;
            end else if (hex_sh == 16'd0 || (hex_sh >= 16'hDC00 && hex_sh <= 16'hDFFF)) begin
              do_fail = 1'b1; fcode = jsu_pkg::E_BAD_CP;
            end else begin
              ent.is_cp = 1'b1;
              ent.val   = {5'd0, hex_sh};
              phase_nxt = PH_STR;
            end
          end
        end
      end
      PH_LOW_BSL: begin
        if (eoi || c != 8'h5C) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_NO_LOW;
        end else begin
          phase_nxt = PH_LOW_U;
        end
      end
      PH_LOW_U: begin
        if (eoi || c != 8'h75) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_NO_LOW;
        end else begin
          phase_nxt = PH_LOW_HEX;
          hex_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      PH_LOW_HEX: begin
        if (eoi) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_NO_LOW;
        end else if (!hv) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_BAD_LOW;
        end else begin
          hex_nxt = hex_sh;
          if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            if (hex_sh < 16'hDC00 || hex_sh > 16'hDFFF) begin
              do_fail = 1'b1; fcode = jsu_pkg::E_BAD_LOW;
            end else begin
              ent.is_cp = 1'b1;
              ent.val   = 21'h10000 + {1'b0, hi_r, hex_sh[9:0]};
              phase_nxt = PH_STR;
            end
          end
        end
      end
      default: begin
        if (eoi || c != 8'h22) begin
          do_fail = 1'b1; fcode = jsu_pkg::E_NO_QUOTE;
        end else begin
          phase_nxt = PH_STR;
          hex_nxt   = '0;
          cnt_nxt   = '0;
          hi_nxt    = '0;
        end
      end
    endcase
    if (do_fail) begin
      ent        = '0;
      ent.status = jsu_pkg::ST_ERR;
      ent.code   = fcode;
      phase_nxt  = PH_IDLE;
      hex_nxt    = '0;
      cnt_nxt    = '0;
      hi_nxt     = '0;
    end
  end

  assign push_cmd = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hex_r   <= '0;
      cnt_r   <= '0;
      hi_r    <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      cnt_r   <= cnt_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

/* sv/jsu_queue.sv */
// Short register queue of result actions between front and back.
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output jsu_pkg::cmd_t head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t    slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

/* sv/jsu_back.sv */
// Back end: expands queued actions into result beats, UTF-8 encoding code points.
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jsu_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_data
);

  logic [jsu_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [jsu_pkg::IDX_W-1:0] nm1;
  logic                      out_valid_r;
  jsu_pkg::out_t             out_r, beat;
  logic                      load, is_last;
  logic [20:0]               cp;
  logic [7:0]                ub;

  assign cp = head_cmd.val;

  always_comb begin
    if (cp <= 21'h7F)        nm1 = 2'd0;
    else if (cp <= 21'h7FF)  nm1 = 2'd1;
    else if (cp <= 21'hFFFF) nm1 = 2'd2;
    else                     nm1 = 2'd3;
  end

  always_comb begin
    ub = 8'h80 | {2'b00, cp[5:0]};
    case (nm1)
      2'd0: ub = cp[7:0];
      2'd1: if (idx_r == 2'd0) ub = 8'hC0 | {3'b000, cp[10:6]};
      2'd2: begin
        if (idx_r == 2'd0)      ub = 8'hE0 | {4'h0, cp[15:12]};
        else if (idx_r == 2'd1) ub = 8'h80 | {2'b00, cp[11:6]};
      end
      default: begin
        if (idx_r == 2'd0)      ub = 8'hF0 | {5'd0, cp[20:18]};
        else if (idx_r == 2'd1) ub = 8'h80 | {2'b00, cp[17:12]};
        else if (idx_r == 2'd2) ub = 8'h80 | {2'b00, cp[11:6]};
      end
    endcase
  end

  assign is_last = !head_cmd.is_cp || (idx_r == nm1);
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    beat.data_byte   = head_cmd.is_cp ? ub : cp[7:0];
    beat.has_data    = head_cmd.is_cp || head_cmd.has_data;
    beat.status      = head_cmd.status;
    beat.error_code  = head_cmd.code;
    beat.error_class = (head_cmd.status == jsu_pkg::ST_ERR) &&
                       (head_cmd.code == jsu_pkg::E_NO_LOW ||
                        head_cmd.code == jsu_pkg::E_BAD_LOW ||
                        head_cmd.code == jsu_pkg::E_BAD_CP);
    beat.last        = is_last;
    if (pop)       idx_nxt = '0;
    else if (load) idx_nxt = idx_r + 2'd1;
    else           idx_nxt = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= beat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/jsu_checker.sv */
// Port-level checker for the JSON string unescape unit, with its bind.
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_unit_assert.svh"

module jsu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input jsu_pkg::out_t out_data
);

  logic stall, is_final, fin_shape, uni_err, quiet_ok;

  assign stall     = out_valid && !out_ready;
  assign is_final  = (out_data.status != jsu_pkg::ST_BUSY);
  assign fin_shape = out_data.last && !out_data.has_data && (out_data.data_byte == 8'd0);
  assign uni_err   = (out_data.status == jsu_pkg::ST_ERR) &&
                     (out_data.error_code == jsu_pkg::E_NO_LOW ||
                      out_data.error_code == jsu_pkg::E_BAD_LOW ||
                      out_data.error_code == jsu_pkg::E_BAD_CP);
  assign quiet_ok  = out_data.last && (is_final || out_data.data_byte == 8'd0);

  `JSU_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(out_data), "stalled beat changed")
  `JSU_ASSERT_NOW(a_final_shape, out_valid && is_final, fin_shape, "done or error beat malformed")
  `JSU_ASSERT_NOW(a_class, out_valid && out_data.error_class, uni_err, "class on wrong code")
  `JSU_ASSERT_NOW(a_quiet_last, out_valid && !out_data.has_data, quiet_ok, "empty beat not last")

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the JSON string unescape unit with UTF-8 output.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF = 4;
  localparam int LIMIT    = 200000;
  localparam int N_RANDOM = 280;

  localparam logic [3:0] NO_ERR = '0;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_B     = "b";
  localparam logic [7:0] CH_F     = "f";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_T     = "t";

  localparam logic [15:0] HI_MIN = 16'hD800;
  localparam logic [15:0] HI_MAX = 16'hDBFF;
  localparam logic [15:0] LO_MIN = 16'hDC00;
  localparam logic [15:0] LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [7:0] ESC_LETTERS [8] =
    '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
  localparam logic [15:0] BMP_EDGES [8] =
    '{16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

  localparam logic [2:0] P_IDLE   = 3'd0;
  localparam logic [2:0] P_BODY   = 3'd1;
  localparam logic [2:0] P_ESC    = 3'd2;
  localparam logic [2:0] P_HEX    = 3'd3;
  localparam logic [2:0] P_LO_BSL = 3'd4;
  localparam logic [2:0] P_LO_U   = 3'd5;
  localparam logic [2:0] P_LO_HEX = 3'd6;

  typedef struct packed {
    jsu_pkg::in_t  b;
    logic          typed;
    jsu_pkg::out_t want;
  } beat_row_t;

  function automatic jsu_pkg::out_t make_beat(input logic [7:0] d, input logic has,
                                              input logic [1:0] st, input logic [3:0] code,
                                              input logic last);
    jsu_pkg::out_t r;
    r.data_byte   = d;
    r.has_data    = has;
    r.status      = st;
    r.error_code  = code;
    r.error_class = (st == jsu_pkg::ST_ERR) && (code >= jsu_pkg::E_NO_LOW) &&
                    (code <= jsu_pkg::E_BAD_CP);
    r.last        = last;
    return r;
  endfunction

  function automatic jsu_pkg::out_t err_beat(input logic [3:0] code);
    return make_beat(8'h00, 1'b0, jsu_pkg::ST_ERR, code, 1'b1);
  endfunction

  localparam jsu_pkg::out_t R_QUIET = make_beat(8'h00, 1'b0, jsu_pkg::ST_BUSY, NO_ERR, 1'b1);
  localparam jsu_pkg::out_t R_DONE  = make_beat(8'h00, 1'b0, jsu_pkg::ST_DONE, NO_ERR, 1'b1);

  // Directed beats; typed rows carry their result, the others go to the predictor.
  localparam beat_row_t DIR_ROWS [30] = '{
    '{'{"a", 1'b0}, 1'b1, err_beat(jsu_pkg::E_NO_QUOTE)},
    '{'{8'h00, 1'b1}, 1'b1, err_beat(jsu_pkg::E_NO_QUOTE)},
    '{'{CH_QUOTE, 1'b0}, 1'b1, R_QUIET},
    '{'{8'hFF, 1'b0}, 1'b1, make_beat(8'hFF, 1'b1, jsu_pkg::ST_BUSY, NO_ERR, 1'b1)},
    '{'{CH_SPACE, 1'b0}, 1'b1, make_beat(CH_SPACE, 1'b1, jsu_pkg::ST_BUSY, NO_ERR, 1'b1)},
    '{'{8'h1F, 1'b0}, 1'b1, err_beat(jsu_pkg::E_CONTROL)},
    '{'{CH_QUOTE, 1'b0}, 1'b1, R_QUIET},
    '{'{CH_BSL, 1'b0}, 1'b1, R_QUIET},
    '{'{8'h00, 1'b1}, 1'b1, err_beat(jsu_pkg::E_END_ESC)},
    '{'{CH_QUOTE, 1'b0}, 1'b1, R_QUIET},
    '{'{CH_BSL, 1'b0}, 1'b1, R_QUIET},
    '{'{"x", 1'b0}, 1'b1, err_beat(jsu_pkg::E_BAD_ESC)},
    '{'{CH_QUOTE, 1'b0}, 1'b1, R_QUIET},
    '{'{CH_BSL, 1'b0}, 1'b1, R_QUIET},
    '{'{CH_U, 1'b0}, 1'b1, R_QUIET},
    '{'{"G", 1'b0}, 1'b1, err_beat(jsu_pkg::E_BAD_HEX)},
    '{'{CH_QUOTE, 1'b0}, 1'b1, R_QUIET},
    '{'{CH_BSL, 1'b0}, 1'b0, R_QUIET},
    '{'{CH_U, 1'b0}, 1'b0, R_QUIET},
    '{'{"D", 1'b0}, 1'b0, R_QUIET},
    '{'{"8", 1'b0}, 1'b0, R_QUIET},
    '{'{"3", 1'b0}, 1'b0, R_QUIET},
    '{'{"d", 1'b0}, 1'b0, R_QUIET},
    '{'{CH_BSL, 1'b0}, 1'b0, R_QUIET},
    '{'{CH_U, 1'b0}, 1'b0, R_QUIET},
    '{'{"d", 1'b0}, 1'b0, R_QUIET},
    '{'{"E", 1'b0}, 1'b0, R_QUIET},
    '{'{"0", 1'b0}, 1'b0, R_QUIET},
    '{'{"0", 1'b0}, 1'b0, R_QUIET},
    '{'{CH_QUOTE, 1'b0}, 1'b1, R_DONE}
  };

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  jsu_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  jsu_pkg::out_t out_data;

  int   cyc = 0;
  int   errs = 0;
  logic calm;

  beat_row_t     rows_q[$];
  jsu_pkg::out_t step_q[$];
  jsu_pkg::out_t decoded_q[$];

  logic [2:0]  ph = P_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_n = '0;
  logic [9:0]  hi_bits = '0;

  json_string_unescape_utf8_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // No idling on either side in this window.
  assign calm = (cyc >= 150) && (cyc < 400);

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    case (c)
      CH_QUOTE: return {1'b1, CH_QUOTE};
      CH_BSL:   return {1'b1, CH_BSL};
      CH_SLASH: return {1'b1, CH_SLASH};
      CH_B:     return {1'b1, 8'h08};
      CH_F:     return {1'b1, 8'h0C};
      CH_N:     return {1'b1, 8'h0A};
      CH_R:     return {1'b1, 8'h0D};
      CH_T:     return {1'b1, 8'h09};
      default:  return '0;
    endcase
  endfunction

  function automatic void push_data(input logic [7:0] d, input logic last);
    step_q.push_back(make_beat(d, 1'b1, jsu_pkg::ST_BUSY, NO_ERR, last));
  endfunction

  function automatic void push_quiet();
    step_q.push_back(R_QUIET);
  endfunction

  function automatic void parse_fail(input logic [3:0] code);
    ph = P_IDLE;
    hex_acc = '0;
    hex_n = '0;
    hi_bits = '0;
    step_q.push_back(err_beat(code));
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_data(cp[7:0], 1'b1);
    end else if (cp <= 21'h7FF) begin
      push_data({3'b110, cp[10:6]}, 1'b0);
      push_data({2'b10, cp[5:0]}, 1'b1);
    end else if (cp <= 21'hFFFF) begin
      push_data({4'b1110, cp[15:12]}, 1'b0);
      push_data({2'b10, cp[11:6]}, 1'b0);
      push_data({2'b10, cp[5:0]}, 1'b1);
    end else begin
      push_data({5'b11110, cp[20:18]}, 1'b0);
      push_data({2'b10, cp[17:12]}, 1'b0);
      push_data({2'b10, cp[11:6]}, 1'b0);
      push_data({2'b10, cp[5:0]}, 1'b1);
    end
    ph = P_BODY;
  endfunction

  // Advances the parser by one input beat, leaving its results in step_q.
  function automatic void unescape_step(input jsu_pkg::in_t b);
    int         h;
    logic [7:0] c;
    logic [8:0] esc;
    logic       eoi;
    c   = b.in_byte;
    eoi = b.end_of_input;
    h   = hex_nibble(c);
    esc = esc_decode(c);
    case (ph)
      P_BODY: begin
        if (eoi) parse_fail(jsu_pkg::E_UNTERM);
        else if (c == CH_QUOTE) begin
          ph = P_IDLE;
          step_q.push_back(R_DONE);
        end else if (c < CH_SPACE) parse_fail(jsu_pkg::E_CONTROL);
        else if (c == CH_BSL) begin
          ph = P_ESC;
          push_quiet();
        end else push_data(c, 1'b1);
      end
      P_ESC: begin
        if (eoi) parse_fail(jsu_pkg::E_END_ESC);
        else if (c == CH_U) begin
          ph = P_HEX;
          hex_acc = '0;
          hex_n = '0;
          push_quiet();
        end else if (esc[8]) begin
          ph = P_BODY;
          push_data(esc[7:0], 1'b1);
        end else parse_fail(jsu_pkg::E_BAD_ESC);
      end
      P_HEX: begin
        if (eoi || h < 0) parse_fail(jsu_pkg::E_BAD_HEX);
        else begin
          hex_acc = {hex_acc[11:0], h[3:0]};
          if (hex_n < 2'd3) begin
            hex_n++;
            push_quiet();
          end else begin
            hex_n = '0;
            if (hex_acc >= HI_MIN && hex_acc <= HI_MAX) begin
              hi_bits = hex_acc[9:0];
              ph = P_LO_BSL;
              push_quiet();
            end else if (hex_acc == '0 || (hex_acc >= LO_MIN && hex_acc <= LO_MAX)) begin
              parse_fail(jsu_pkg::E_BAD_CP);
            end else emit_utf8({5'b0, hex_acc});
          end
        end
      end
      P_LO_BSL: begin
        if (eoi || c != CH_BSL) parse_fail(jsu_pkg::E_NO_LOW);
        else begin
          ph = P_LO_U;
          push_quiet();
        end
      end
      P_LO_U: begin
        if (eoi || c != CH_U) parse_fail(jsu_pkg::E_NO_LOW);
        else begin
          ph = P_LO_HEX;
          hex_acc = '0;
          hex_n = '0;
          push_quiet();
        end
      end
      P_LO_HEX: begin
        if (eoi) parse_fail(jsu_pkg::E_NO_LOW);
        else if (h < 0) parse_fail(jsu_pkg::E_BAD_LOW);
        else begin
          hex_acc = {hex_acc[11:0], h[3:0]};
          if (hex_n < 2'd3) begin
            hex_n++;
            push_quiet();
          end else begin
            hex_n = '0;
            if (hex_acc < LO_MIN || hex_acc > LO_MAX) parse_fail(jsu_pkg::E_BAD_LOW);
            else emit_utf8(SUPP_BASE + {1'b0, hi_bits, hex_acc[9:0]});
          end
        end
      end
      default: begin
        if (eoi || c != CH_QUOTE) parse_fail(jsu_pkg::E_NO_QUOTE);
        else begin
          ph = P_BODY;
          hex_acc = '0;
          hex_n = '0;
          hi_bits = '0;
          push_quiet();
        end
      end
    endcase
  endfunction

  // Random text generation.
  function automatic void add_byte(input logic [7:0] c);
    beat_row_t r;
    r = '0;
    r.b.in_byte = c;
    rows_q.push_back(r);
  endfunction

  function automatic void add_end();
    beat_row_t r;
    r = '0;
    r.b.in_byte = 8'($urandom_range(0, 255));
    r.b.end_of_input = 1'b1;
    rows_q.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n - 4'd10);
  endfunction

  function automatic void add_u(input logic [15:0] v);
    add_byte(CH_BSL);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(1, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return BMP_EDGES[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [15:0] pick_surr(input logic [15:0] lo, input logic [15:0] hi);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? lo : hi;
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [7:0] pick_bad_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic void add_good_digits(input int k);
    for (int i = 0; i < k; i++) add_byte(hex_char(4'($urandom_range(0, 15))));
  endfunction

  // One malformed escape or byte; the string ends there.
  function automatic void add_broken();
    logic [7:0] c;
    logic [8:0] esc;
    logic [7:0] seq [12];
    logic [15:0] hi;
    logic [15:0] lo;
    int n;
    hi = pick_surr(HI_MIN, HI_MAX);
    lo = pick_surr(LO_MIN, LO_MAX);
    case ($urandom_range(0, 9))
      0: add_byte(8'($urandom_range(0, 31)));
      1: begin
        do begin
          c   = 8'($urandom_range(0, 255));
          esc = esc_decode(c);
        end while (esc[8] || c == CH_U);
        add_byte(CH_BSL);
        add_byte(c);
      end
      2: begin
        add_byte(CH_BSL);
        add_byte(CH_U);
        add_good_digits($urandom_range(0, 3));
        add_byte(pick_bad_hex());
      end
      3: add_u(16'h0000);
      4: add_u(lo);
      5: begin
        add_u(hi);
        do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
        add_byte(c);
      end
      6: begin
        add_u(hi);
        add_byte(CH_BSL);
        do c = 8'($urandom_range(0, 255)); while (c == CH_U);
        add_byte(c);
      end
      7: begin
        add_u(hi);
        add_byte(CH_BSL);
        add_byte(CH_U);
        add_good_digits($urandom_range(0, 3));
        add_byte(pick_bad_hex());
      end
      8: begin
        add_u(hi);
        add_u($urandom_range(0, 1) ? 16'($urandom_range(0, 16'hDBFF))
                                   : 16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      default: begin
        // cut off somewhere inside a surrogate pair
        seq[0] = CH_BSL;
        seq[1] = CH_U;
        seq[6] = CH_BSL;
        seq[7] = CH_U;
        for (int i = 0; i < 4; i++) begin
          seq[2 + i] = hex_char(hi[4*(3-i) +: 4]);
          seq[8 + i] = hex_char(lo[4*(3-i) +: 4]);
        end
        n = $urandom_range(1, 11);
        for (int i = 0; i < n; i++) add_byte(seq[i]);
        add_end();
      end
    endcase
  endfunction

  function automatic void add_string();
    logic [7:0] c;
    int nseg;
    int roll;
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 2) == 0) add_end();
      else add_byte(8'($urandom_range(0, 255)));
      return;
    end
    add_byte(CH_QUOTE);
    nseg = $urandom_range(0, 6);
    for (int s = 0; s < nseg; s++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
        add_byte(c);
      end else if (roll < 55) begin
        add_byte(CH_BSL);
        add_byte(ESC_LETTERS[$urandom_range(0, 7)]);
      end else if (roll < 75) begin
        add_u(pick_bmp());
      end else if (roll < 86) begin
        add_u(pick_surr(HI_MIN, HI_MAX));
        add_u(pick_surr(LO_MIN, LO_MAX));
      end else begin
        add_broken();
        return;
      end
    end
    if ($urandom_range(0, 99) < 88) add_byte(CH_QUOTE);
    else add_end();
  endfunction

  function automatic logic gap_now();
    return !calm && ($urandom_range(0, 99) < 35);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cyc, what);
    errs++;
  endtask

  task automatic check_beat(input jsu_pkg::out_t got);
    jsu_pkg::out_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %h", got));
      return;
    end
    want = decoded_q.pop_front();
    if (got.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte %h want %h", got.data_byte, want.data_byte));
    if (got.has_data !== want.has_data)
      report_mismatch($sformatf("has_data %b want %b", got.has_data, want.has_data));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d want %0d", got.error_code, want.error_code));
    if (got.error_class !== want.error_class)
      report_mismatch($sformatf("error_class %b want %b", got.error_class, want.error_class));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b want %b", got.last, want.last));
  endtask

  task automatic drive_row(input beat_row_t r);
    while (gap_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.b;
    do @(posedge clk); while (!in_ready);
    step_q.delete();
    unescape_step(r.b);
    if (r.typed) decoded_q.push_back(r.want);
    else foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 35);
      if (out_valid && out_ready) check_beat(out_data);
    end
  end

  initial begin
    while (cyc < LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    foreach (DIR_ROWS[i]) rows_q.push_back(DIR_ROWS[i]);
    while (rows_q.size() < $size(DIR_ROWS) + N_RANDOM) add_string();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows_q[i]) drive_row(rows_q[i]);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
